### design/lsab_pkg.sv
// ----------------------------------------------------------------------------
// lsab_pkg
// Shared widths, codes and item types of the lidar scan angle binner.
// ----------------------------------------------------------------------------
package lsab_pkg;

    // Largest supported bin count and widths sized for it
    localparam int MAX_BINS_DEF = 512;
    localparam int BIN_W        = 13;              // holds a bin count up to 8191
    localparam int ANG_W        = 18;              // signed angle, relative angle, span
    localparam int NUM_W        = ANG_W + BIN_W;   // signed rel * n
    localparam int DIV_W        = NUM_W + 1;       // 2*|num| + span
    localparam int ERR_W        = 26;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [ANG_W-1:0] FULL_TURN = ANG_W'(36000);
    localparam logic [ERR_W-1:0] NO_POINT  = 26'h3FFFFFF;
    localparam logic [ERR_W-1:0] ERR_SAT   = 26'h3FFFFFE;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_END    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCKWISE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT  = 3'd5;

    // Item operation codes
    localparam logic OP_POINT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Classified item handed from front to back
    typedef struct packed {
        logic                    is_read;
        logic                    rd_ok;
        logic [BIN_W-1:0]        bin;
        logic signed [ANG_W-1:0] rel;
        logic signed [ANG_W-1:0] span;
        logic [BIN_W-1:0]        n;
        logic                    dist_ok;
        logic [15:0]             dist_mm;
        logic [7:0]              inten;
    } t_job;

    // Result item
    typedef struct packed {
        logic [15:0] range_mm;
        logic [7:0]  inten;
        logic        claimed;
    } t_res;

    // Stored bin entry
    typedef struct packed {
        logic [ERR_W-1:0] best;
        logic [7:0]       inten;
        logic [15:0]      range_mm;
    } t_entry;

endpackage

### design/lsab_queue.sv
// ----------------------------------------------------------------------------
// lsab_queue
// Small synchronous FIFO used between the front, the back and the result port.
// ----------------------------------------------------------------------------
module lsab_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store incoming item
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

### design/lsab_div.sv
// ----------------------------------------------------------------------------
// lsab_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsab_div #(
    parameter int DW = 32,
    parameter int VW = 18
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quo,
    output logic [VW-1:0] o_rem
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [VW:0]   trial;
    logic          fits;

    // Shift in the next dividend bit and try a subtract
    assign trial = {r_rem, r_quo[DW-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[DW-2:0], fits};
                r_rem <= fits ? VW'(trial - {1'b0, r_dvs}) : trial[VW-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

### design/lsab_front.sv
// ----------------------------------------------------------------------------
// lsab_front
// Configuration registers and item classification: mirror, window, span.
// ----------------------------------------------------------------------------
module lsab_front #(
    parameter int MAX_BINS = lsab_pkg::MAX_BINS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lsab_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data,
    input  logic                           i_op,
    input  logic [15:0]                    i_point_angle,
    input  logic [15:0]                    i_point_distance,
    input  logic [7:0]                     i_point_intensity,
    input  logic [8:0]                     i_read_bin,
    output logic                           o_keep,
    output lsab_pkg::t_job                 o_job
);
    import lsab_pkg::*;

    logic [15:0] r_win_start, r_win_end, r_near, r_far;
    logic        r_cw;
    logic [9:0]  r_bin_count;

    logic signed [ANG_W-1:0] angle, start, stop, rel_raw, rel, span;
    logic                    in_window;
    logic [BIN_W-1:0]        n;

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start <= 16'd0;
            r_win_end   <= 16'd36000;
            r_near      <= 16'd50;
            r_far       <= 16'd12000;
            r_cw        <= 1'b0;
            r_bin_count <= 10'd450;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIN_START:  r_win_start <= i_cfg_data;
                CFG_WIN_END:    r_win_end   <= i_cfg_data;
                CFG_NEAR_LIMIT: r_near      <= i_cfg_data;
                CFG_FAR_LIMIT:  r_far       <= i_cfg_data;
                CFG_CLOCKWISE:  r_cw        <= i_cfg_data[0];
                CFG_BIN_COUNT:  r_bin_count <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Mirror angle, test the window, form span and relative angle, clamp bin count
    always_comb begin
        start = $signed({2'b00, r_win_start});
        stop  = $signed({2'b00, r_win_end});
        angle = $signed({2'b00, i_point_angle});
        if (!r_cw) begin
            angle = $signed(FULL_TURN) - angle;
            if (angle >= $signed(FULL_TURN)) begin
                angle = angle - $signed(FULL_TURN);
            end
        end
        if (start <= stop) begin
            in_window = (angle >= start) && (angle <= stop);
        end else begin
            in_window = (angle >= start) || (angle <= stop);
        end
        span    = (stop >= start) ? stop - start : ($signed(FULL_TURN) - start) + stop;
        rel_raw = angle - start;
        rel     = (rel_raw < 0) ? rel_raw + $signed(FULL_TURN) : rel_raw;
        if (r_bin_count < 10'd2) begin
            n = BIN_W'(2);
        end else if (32'(r_bin_count) > MAX_BINS) begin
            n = BIN_W'(MAX_BINS);
        end else begin
            n = BIN_W'(r_bin_count);
        end
    end

    // Drop points outside the window
    assign o_keep = (i_op == OP_READ) || in_window;

    always_comb begin
        o_job.is_read = (i_op == OP_READ);
        o_job.rd_ok   = (32'(i_read_bin) < MAX_BINS);
        o_job.bin     = BIN_W'(i_read_bin);
        o_job.rel     = rel;
        o_job.span    = span;
        o_job.n       = n;
        o_job.dist_ok = (i_point_distance >= r_near) && (i_point_distance <= r_far);
        o_job.dist_mm = i_point_distance;
        o_job.inten   = i_point_intensity;
    end
endmodule

### design/lsab_back.sv
// ----------------------------------------------------------------------------
// lsab_back
// Bin index and error computation, bin store update, read and clear.
// ----------------------------------------------------------------------------
module lsab_back #(
    parameter int MAX_BINS = lsab_pkg::MAX_BINS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_empty,
    input  lsab_pkg::t_job i_job,
    output logic           o_job_pop,
    input  logic           i_res_full,
    output logic           o_res_push,
    output lsab_pkg::t_res o_res
);
    import lsab_pkg::*;

    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_RDW, S_NUM, S_DGO1, S_DW1, S_DGO2, S_DW2,
        S_PROD, S_ERR, S_CMP
    } t_state;

    t_state                  r_state;
    t_job                    r_job;
    logic [AW-1:0]           r_clr;
    logic signed [NUM_W-1:0] r_num;
    logic [DIV_W-1:0]        r_q;
    logic [BIN_W-1:0]        r_s;
    logic signed [NUM_W-1:0] r_prod;
    logic [ERR_W-1:0]        r_err;
    t_entry                  r_mem [MAX_BINS];
    t_entry                  r_rdata;

    logic                    rd_en, we;
    logic [AW-1:0]           rd_addr, wr_addr;
    t_entry                  wdata;
    logic                    div_start, div_done;
    logic [DIV_W-1:0]        div_dvd, div_quo;
    logic [ANG_W-1:0]        div_dvs, div_rem;
    logic [NUM_W-1:0]        num_abs;
    logic [BIN_W-1:0]        m;
    logic signed [NUM_W:0]   diff;
    logic [NUM_W:0]          diff_abs;

    lsab_div #(.DW(DIV_W), .VW(ANG_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // Rounded quotient first, then its remainder by the bin count
    assign num_abs   = (r_num < 0) ? NUM_W'(-r_num) : NUM_W'(r_num);
    assign div_start = (r_state == S_DGO1) || (r_state == S_DGO2);
    assign div_dvd   = (r_state == S_DGO1)
                     ? DIV_W'({num_abs, 1'b0}) + DIV_W'(r_job.span) : r_q;
    assign div_dvs   = (r_state == S_DGO1)
                     ? ANG_W'({r_job.span, 1'b0}) : ANG_W'(r_job.n);
    assign m         = div_rem[BIN_W-1:0];

    assign diff     = $signed({r_num[NUM_W-1], r_num}) - $signed({r_prod[NUM_W-1], r_prod});
    assign diff_abs = (diff < 0) ? (NUM_W + 1)'(-diff) : (NUM_W + 1)'(diff);

    // Memory port control
    always_comb begin
        rd_en   = (r_state == S_RD) || (r_state == S_PROD);
        rd_addr = (r_state == S_RD) ? r_job.bin[AW-1:0] : r_s[AW-1:0];
        we      = 1'b0;
        wr_addr = r_clr;
        wdata   = '{best: NO_POINT, inten: 8'd0, range_mm: 16'd0};
        case (r_state)
            S_CLEAR: we = 1'b1;
            S_RDW: begin
                we      = !i_res_full && r_job.rd_ok;
                wr_addr = r_job.bin[AW-1:0];
            end
            S_CMP: begin
                we         = (r_err < r_rdata.best);
                wr_addr    = r_s[AW-1:0];
                wdata.best = r_err;
                if (r_job.dist_ok) begin
                    wdata.inten    = r_job.inten;
                    wdata.range_mm = r_job.dist_mm;
                end else begin
                    wdata.inten    = r_rdata.inten;
                    wdata.range_mm = r_rdata.range_mm;
                end
            end
            default: ;
        endcase
    end

    // Bin store
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wdata;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Result and job handshakes
    assign o_job_pop  = (r_state == S_IDLE) && !i_job_empty;
    assign o_res_push = (r_state == S_RDW) && !i_res_full;
    always_comb begin
        if (r_job.rd_ok) begin
            o_res.range_mm = r_rdata.range_mm;
            o_res.inten    = r_rdata.inten;
            o_res.claimed  = (r_rdata.best != NO_POINT);
        end else begin
            o_res = '0;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(MAX_BINS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_job   <= i_job;
                        r_state <= i_job.is_read ? S_RD : S_NUM;
                    end
                end
                S_RD:  r_state <= S_RDW;
                S_RDW: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                S_NUM: begin
                    r_num   <= NUM_W'(r_job.rel) * NUM_W'($signed({1'b0, r_job.n}));
                    r_s     <= '0;
                    r_state <= (r_job.span > 0) ? S_DGO1 : S_PROD;
                end
                S_DGO1: r_state <= S_DW1;
                S_DW1: begin
                    if (div_done) begin
                        r_q     <= div_quo;
                        r_state <= S_DGO2;
                    end
                end
                S_DGO2: r_state <= S_DW2;
                S_DW2: begin
                    if (div_done) begin
                        r_s     <= ((r_num < 0) && (m != '0)) ? r_job.n - m : m;
                        r_state <= S_PROD;
                    end
                end
                S_PROD: begin
                    r_prod  <= NUM_W'($signed({1'b0, r_s})) * NUM_W'(r_job.span);
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_err   <= (diff_abs > (NUM_W + 1)'(ERR_SAT)) ? ERR_SAT
                                                                  : ERR_W'(diff_abs);
                    r_state <= S_CMP;
                end
                S_CMP:   r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### design/lidar_scan_angle_binner_core.sv
// ----------------------------------------------------------------------------
// lidar_scan_angle_binner_core
// Resamples lidar points into equal angle bins, read and clear per bin.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | push / full            | i_op, i_point_angle, i_point_distance,
//           |                        | i_point_intensity, i_read_bin
//  result   | pop / empty            | o_bin_range_mm, o_bin_intensity,
//           |                        | o_bin_claimed
//  config   | cfg_valid / cfg_ready  | i_cfg_index, i_cfg_data
//
// In the back end a point makes two passes through the serial divider
// (rounded quotient, then modulo bin count), each with start and finish.
// A point with zero or negative span skips the divider. Points outside the
// window are dropped at the front. After reset the bin store is cleared
// bin by bin; items queue up but are not processed until then. A full
// result queue holds a read item in the back end, and the items behind it
// wait in the job queue.
// ----------------------------------------------------------------------------
module lidar_scan_angle_binner_core #(
    parameter int MAX_BINS = lsab_pkg::MAX_BINS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lsab_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_op,
    input  logic [15:0]                    i_point_angle,
    input  logic [15:0]                    i_point_distance,
    input  logic [7:0]                     i_point_intensity,
    input  logic [8:0]                     i_read_bin,
    output logic                           empty,
    input  logic                           pop,
    output logic [15:0]                    o_bin_range_mm,
    output logic [7:0]                     o_bin_intensity,
    output logic                           o_bin_claimed
);
    import lsab_pkg::*;

    logic keep;
    t_job front_job, back_job;
    logic job_empty, job_pop;
    logic res_full, res_push;
    t_res back_res, out_res;

    assign cfg_ready = 1'b1;

    lsab_front #(.MAX_BINS(MAX_BINS)) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_valid && cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_op              (i_op),
        .i_point_angle     (i_point_angle),
        .i_point_distance  (i_point_distance),
        .i_point_intensity (i_point_intensity),
        .i_read_bin        (i_read_bin),
        .o_keep            (keep),
        .o_job             (front_job)
    );

    // Queue classified items between front and back
    lsab_queue #(.W($bits(t_job)), .DEPTH(QUEUE_DEPTH)) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && keep),
        .i_data  (front_job),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_data  (back_job)
    );

    lsab_back #(.MAX_BINS(MAX_BINS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (back_job),
        .o_job_pop   (job_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    // Hold results until taken
    lsab_queue #(.W($bits(t_res)), .DEPTH(QUEUE_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_res)
    );

    assign o_bin_range_mm  = out_res.range_mm;
    assign o_bin_intensity = out_res.inten;
    assign o_bin_claimed   = out_res.claimed;
endmodule

### bench/lsab_checker.sv
// ----------------------------------------------------------------------------
// lsab_checker
// Watches the config, input and result channels of the angle binner, keeps
// its own copy of the bin stores and configuration, predicts every read
// result and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module lsab_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [lsab_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data,
    input  logic                           push,
    input  logic                           full,
    input  logic                           i_op,
    input  logic [15:0]                    i_point_angle,
    input  logic [15:0]                    i_point_distance,
    input  logic [7:0]                     i_point_intensity,
    input  logic [8:0]                     i_read_bin,
    input  logic                           empty,
    input  logic                           pop,
    input  logic [15:0]                    o_bin_range_mm,
    input  logic [7:0]                     o_bin_intensity,
    input  logic                           o_bin_claimed,
    output int                             o_errors,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lsab_pkg::*;

    localparam int NBINS = MAX_BINS_DEF;

    // Mirror of the bin stores
    logic [15:0]      range_mem [NBINS];
    logic [7:0]       inten_mem [NBINS];
    logic [ERR_W-1:0] best_mem  [NBINS];

    // Mirror of the configuration
    logic [15:0] win_start, win_end, near_mm, far_mm;
    logic        clockwise;
    logic [9:0]  bins_cfg;

    t_res bin_reads_due [$];

    // Bin a measured point and keep it if it beats the bin's best error
    function automatic void bin_point(logic [15:0] ang_in, logic [15:0] dist_mm,
                                      logic [7:0] inten);
        longint ang, st, en, span, rel, n, num, q, s, err;
        int     idx;
        bit     in_win;
        ang = ang_in;
        if (!clockwise) begin
            ang = longint'(FULL_TURN) - ang;
            if (ang >= longint'(FULL_TURN)) ang -= longint'(FULL_TURN);
        end
        st = win_start;
        en = win_end;
        if (st <= en) in_win = (ang >= st) && (ang <= en);
        else          in_win = (ang >= st) || (ang <= en);
        if (!in_win) return;
        span = (en >= st) ? en - st : (longint'(FULL_TURN) - st) + en;
        n = bins_cfg;
        if (n < 2) n = 2;
        if (n > NBINS) n = NBINS;
        rel = ang - st;
        if (rel < 0) rel += longint'(FULL_TURN);
        if (span <= 0) begin
            idx = 0;
            err = (rel < 0 ? -rel : rel) * n;
        end else begin
            num = rel * n;
            q = (2 * (num < 0 ? -num : num) + span) / (2 * span);
            s = (num < 0) ? -q : q;
            s = s % n;
            if (s < 0) s += n;
            idx = int'(s);
            err = num - s * span;
            if (err < 0) err = -err;
        end
        if (err > longint'(ERR_SAT)) err = longint'(ERR_SAT);
        if (err >= longint'(best_mem[idx])) return;
        best_mem[idx] = ERR_W'(err);
        if (dist_mm >= near_mm && dist_mm <= far_mm) begin
            range_mem[idx] = dist_mm;
            inten_mem[idx] = inten;
        end
    endfunction

    always @(posedge i_clk) begin
        t_res got, want;
        if (!i_rst_n) begin
            for (int b = 0; b < NBINS; b++) begin
                range_mem[b] = '0;
                inten_mem[b] = '0;
                best_mem[b]  = NO_POINT;
            end
            win_start = 16'd0;
            win_end   = 16'd36000;
            near_mm   = 16'd50;
            far_mm    = 16'd12000;
            clockwise = 1'b0;
            bins_cfg  = 10'd450;
            bin_reads_due.delete();
            o_errors = 0;
        end else begin
            // Compare a popped bin against the oldest expectation
            if (pop && !empty) begin
                got.range_mm = o_bin_range_mm;
                got.inten    = o_bin_intensity;
                got.claimed  = o_bin_claimed;
                if (bin_reads_due.size() == 0) begin
                    $display("%0t: unexpected result range=%0d inten=%0d claimed=%0d",
                             $time, got.range_mm, got.inten, got.claimed);
                    o_errors++;
                end else begin
                    want = bin_reads_due.pop_front();
                    if (got.range_mm !== want.range_mm) begin
                        $display("%0t: bin_range_mm expected %0d actual %0d",
                                 $time, want.range_mm, got.range_mm);
                        o_errors++;
                    end
                    if (got.inten !== want.inten) begin
                        $display("%0t: bin_intensity expected %0d actual %0d",
                                 $time, want.inten, got.inten);
                        o_errors++;
                    end
                    if (got.claimed !== want.claimed) begin
                        $display("%0t: bin_claimed expected %0d actual %0d",
                                 $time, want.claimed, got.claimed);
                        o_errors++;
                    end
                end
            end
            // Track register writes
            if (cfg_valid && cfg_ready) begin
                case (i_cfg_index)
                    CFG_WIN_START:  win_start = i_cfg_data;
                    CFG_WIN_END:    win_end   = i_cfg_data;
                    CFG_NEAR_LIMIT: near_mm   = i_cfg_data;
                    CFG_FAR_LIMIT:  far_mm    = i_cfg_data;
                    CFG_CLOCKWISE:  clockwise = i_cfg_data[0];
                    CFG_BIN_COUNT:  bins_cfg  = i_cfg_data[9:0];
                    default: ;
                endcase
            end
            // Apply an accepted item
            if (push && !full) begin
                if (i_op == OP_READ) begin
                    want.range_mm = range_mem[i_read_bin];
                    want.inten    = inten_mem[i_read_bin];
                    want.claimed  = (best_mem[i_read_bin] != NO_POINT);
                    bin_reads_due.push_back(want);
                    range_mem[i_read_bin] = '0;
                    inten_mem[i_read_bin] = '0;
                    best_mem[i_read_bin]  = NO_POINT;
                end else begin
                    bin_point(i_point_angle, i_point_distance, i_point_intensity);
                end
            end
        end
        o_pending = bin_reads_due.size();
    end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the angle binner through a set of window, limit, direction and bin
// count settings with directed and random points and bin reads, with random
// stalls on both queues but in the last stretch; the checker predicts and compares every read.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lsab_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 300;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;
    logic                 push;
    logic                 full;
    logic                 i_op;
    logic [15:0]          i_point_angle;
    logic [15:0]          i_point_distance;
    logic [7:0]           i_point_intensity;
    logic [8:0]           i_read_bin;
    logic                 empty;
    logic                 pop;
    logic [15:0]          o_bin_range_mm;
    logic [7:0]           o_bin_intensity;
    logic                 o_bin_claimed;

    int errors;
    int reads_pending;
    int cycles = 0;
    bit jitter_on;
    int pop_hold;
    int bins_now;

    lidar_scan_angle_binner_core uut (.*);

    lsab_checker chk (
        .i_clk, .i_rst_n, .cfg_valid, .cfg_ready, .i_cfg_index, .i_cfg_data,
        .push, .full, .i_op, .i_point_angle, .i_point_distance,
        .i_point_intensity, .i_read_bin, .empty, .pop, .o_bin_range_mm,
        .o_bin_intensity, .o_bin_claimed, .o_errors(errors),
        .o_pending(reads_pending)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: pop with random stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop      <= 1'b0;
            pop_hold <= 0;
        end else if (pop_hold > 0) begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else if (jitter_on && $urandom_range(0, 4) == 0) begin
            pop      <= 1'b0;
            pop_hold <= $urandom_range(0, 2);
        end else begin
            pop <= 1'b1;
        end
    end

    // Send one item, keeping push high for the next one
    task automatic send_item(logic op, logic [15:0] ang, logic [15:0] dist_mm,
                             logic [7:0] inten, logic [8:0] bin);
        if (jitter_on && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        push              <= 1'b1;
        i_op              <= op;
        i_point_angle     <= ang;
        i_point_distance  <= dist_mm;
        i_point_intensity <= inten;
        i_read_bin        <= bin;
        do @(posedge i_clk); while (full);
    endtask

    // Hold until every read has come back and the back end has settled
    task automatic drain();
        push <= 1'b0;
        while (reads_pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    // Write every register, only while idle
    task automatic configure(int ws, int we, int nr, int fr, bit cw, int bc);
        cfg_write(CFG_WIN_START, 16'(ws));
        cfg_write(CFG_WIN_END, 16'(we));
        cfg_write(CFG_NEAR_LIMIT, 16'(nr));
        cfg_write(CFG_FAR_LIMIT, 16'(fr));
        cfg_write(CFG_CLOCKWISE, 16'(cw));
        cfg_write(CFG_BIN_COUNT, 16'(bc));
        cfg_valid <= 1'b0;
        bins_now = bc;
    endtask

    // Random points with reads mixed in; most reads hit bins in use
    task automatic random_run(int count, bit pause_midway);
        for (int k = 0; k < count; k++) begin
            if (pause_midway && k == count / 2) drain();
            if ($urandom_range(0, 9) < 7)
                send_item(OP_POINT, 16'($urandom_range(0, 35999)),
                          ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                              16'($urandom_range(0, 14000)),
                          8'($urandom), 9'($urandom));
            else
                send_item(OP_READ, 16'($urandom), 16'($urandom), 8'($urandom),
                          ($urandom_range(0, 7) == 0) ? 9'($urandom) :
                              9'($urandom_range(0, bins_now - 1)));
        end
        drain();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        cfg_valid         = 1'b0;
        i_cfg_index       = CFG_WIN_START;
        i_cfg_data        = '0;
        push              = 1'b0;
        i_op              = OP_POINT;
        i_point_angle     = '0;
        i_point_distance  = '0;
        i_point_intensity = '0;
        i_read_bin        = '0;
        jitter_on         = 1'b1;
        bins_now          = 450;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full circle, clockwise, widest limits, most bins
        configure(0, 36000, 0, 65535, 1'b1, 512);
        send_item(OP_POINT, 16'd0, 16'd0, 8'd0, 9'd0);
        send_item(OP_POINT, 16'd35999, 16'd65535, 8'd255, 9'd0);
        send_item(OP_POINT, 16'd18000, 16'd1234, 8'd77, 9'd0);
        send_item(OP_POINT, 16'd18010, 16'd999, 8'd12, 9'd0);
        send_item(OP_READ, 16'd0, 16'd0, 8'd0, 9'd0);
        send_item(OP_READ, 16'd0, 16'd0, 8'd0, 9'd0);
        send_item(OP_READ, 16'd0, 16'd0, 8'd0, 9'd256);
        send_item(OP_READ, 16'd0, 16'd0, 8'd0, 9'd511);
        drain();

        // Counter-clockwise, wrapping window, distance limits hit
        configure(30000, 6000, 100, 5000, 1'b0, 2);
        send_item(OP_POINT, 16'd0, 16'd99, 8'd1, 9'd0);
        send_item(OP_POINT, 16'd3000, 16'd5001, 8'd2, 9'd0);
        send_item(OP_POINT, 16'd33000, 16'd100, 8'd3, 9'd0);
        send_item(OP_POINT, 16'd18000, 16'd200, 8'd4, 9'd0);
        send_item(OP_READ, 16'd0, 16'd0, 8'd0, 9'd0);
        send_item(OP_READ, 16'd0, 16'd0, 8'd0, 9'd1);
        send_item(OP_READ, 16'd0, 16'd0, 8'd0, 9'd2);
        drain();

        // Zero span: every point in the window lands in bin 0
        configure(1000, 1000, 65535, 0, 1'b1, 3);
        send_item(OP_POINT, 16'd1000, 16'd500, 8'd9, 9'd0);
        send_item(OP_POINT, 16'd35000, 16'd500, 8'd9, 9'd0);
        send_item(OP_READ, 16'd0, 16'd0, 8'd0, 9'd0);
        drain();

        // Random phases across settings
        configure(0, 36000, 50, 12000, 1'b0, 450);
        random_run(160, 1'b1);
        configure(36000, 0, 0, 65535, 1'b1, 2);
        random_run(120, 1'b0);
        configure(9000, 27000, 300, 8000, 1'b1, 37);
        random_run(160, 1'b0);
        configure(27000, 9000, 0, 65535, 1'b0, 16);
        random_run(160, 1'b0);
        configure(0, 36000, 0, 65535, 1'b1, 512);
        random_run(180, 1'b0);
        configure(12345, 12345, 10, 20000, 1'b0, 5);
        random_run(100, 1'b0);
        configure($urandom_range(0, 36000), $urandom_range(0, 36000),
                  $urandom_range(0, 2000), $urandom_range(3000, 65535),
                  1'($urandom), $urandom_range(2, 512));
        random_run(120, 1'b0);

        // Last stretch without stalls
        jitter_on = 1'b0;
        configure(500, 35500, 0, 65535, 1'b1, 64);
        random_run(130, 1'b0);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
